>>> rtl/sample_to_png_depth_formatter_macros.svh
// Assertion macros for the sample-to-PNG depth formatter.
// Each macro expects clk and arst_n in the scope that uses it.
`ifndef SAMPLE_TO_PNG_DEPTH_FORMATTER_MACROS_SVH
`define SAMPLE_TO_PNG_DEPTH_FORMATTER_MACROS_SVH

// same-cycle implication
`define SPDF_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("spdf: same-cycle check failed");

// next-cycle implication
`define SPDF_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("spdf: next-cycle check failed");

`endif

>>> rtl/spdf_pkg.sv
// Shared types, constants and helpers of the sample-to-PNG depth formatter.
// No dependencies.
`default_nettype none
package spdf_pkg;

	typedef enum logic [1:0] {
		REG_SAMPLE_PREC = 2'd0,
		REG_ALPHA_PREC  = 2'd1,
		REG_COMP_COUNT  = 2'd2,
		REG_SIGNED_MASK = 2'd3
	} cfg_reg_t;

	localparam logic [4:0]  SAMPLE_PREC_RST = 5'd8;
	localparam logic [4:0]  ALPHA_PREC_RST  = 5'd8;
	localparam logic [2:0]  COMP_COUNT_RST  = 3'd3;
	localparam logic [3:0]  SIGNED_MASK_RST = 4'd0;
	localparam logic [15:0] LIM16           = 16'hffff;
	localparam logic [15:0] LIM8            = 16'h00ff;

	typedef struct packed {
		logic [4:0] sample_precision;
		logic [4:0] alpha_precision;
		logic [2:0] component_count;
		logic [3:0] signed_mask;
	} cfg_t;

	typedef struct packed {
		logic [1:0] idx;
		logic       last;
		logic       is_alpha;
	} ctl_t;

	typedef struct packed {
		logic [7:0] high_byte;
		logic [7:0] low_byte;
		logic       two_bytes;
		logic       pixel_end;
		logic       depth_error;
	} res_t;

	// zero reads as one component, five to seven as four
	function automatic logic [2:0] norm_count(input logic [2:0] cc);
		logic [2:0] n;
		n = cc;
		if (cc == 3'd0)
			n = 3'd1;
		else if (cc > 3'd4)
			n = 3'd4;
		return n;
	endfunction

endpackage
`default_nettype wire

>>> rtl/sample_to_png_depth_formatter.sv
// Top level of the sample-to-PNG depth formatter: configuration registers,
// input and result pipeline registers. Depends on spdf_pkg, spdf_comp_ctr,
// spdf_format and the assertion macro header.
//
//   channel   handshake               payload
//   cfg       cfg_we                  cfg_index, cfg_data
//   in        in_valid / in_ready     sample_value
//   out       out_valid / out_ready   high_byte, low_byte, two_bytes,
//                                     pixel_end, depth_error
//
// Each sample is registered in the input stage, then the result stage. One
// sample a cycle unless stalled; the rate is set by these two registers.
// A stalled result holds the result stage; the input stage keeps filling
// until both stages are full. in_ready follows out_ready combinationally.
// Reset clears the configuration to defaults, the component counter and
// both valid flags.
`default_nettype none
`include "sample_to_png_depth_formatter_macros.svh"
module sample_to_png_depth_formatter (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [4:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic signed [31:0] sample_value,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       high_byte,
	output logic [7:0]       low_byte,
	output logic             two_bytes,
	output logic             pixel_end,
	output logic             depth_error
);

	spdf_pkg::cfg_t cfg_q;
	spdf_pkg::ctl_t ctl_in;
	spdf_pkg::ctl_t ctl_s1;
	spdf_pkg::res_t res_comb;
	spdf_pkg::res_t res_s2;
	logic [31:0]    sample_s1;
	logic           valid_s1;
	logic           valid_s2;
	logic           ready_s2;
	logic           accept;

	assign ready_s2 = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || ready_s2;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sample_precision <= spdf_pkg::SAMPLE_PREC_RST;
			cfg_q.alpha_precision  <= spdf_pkg::ALPHA_PREC_RST;
			cfg_q.component_count  <= spdf_pkg::COMP_COUNT_RST;
			cfg_q.signed_mask      <= spdf_pkg::SIGNED_MASK_RST;
		end else if (cfg_we) begin
			unique case (spdf_pkg::cfg_reg_t'(cfg_index))
				spdf_pkg::REG_SAMPLE_PREC: cfg_q.sample_precision <= cfg_data;
				spdf_pkg::REG_ALPHA_PREC:  cfg_q.alpha_precision  <= cfg_data;
				spdf_pkg::REG_COMP_COUNT:  cfg_q.component_count  <= cfg_data[2:0];
				spdf_pkg::REG_SIGNED_MASK: cfg_q.signed_mask      <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	spdf_comp_ctr u_ctr (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.advance (accept),
		.ctl     (ctl_in)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample_value;
			ctl_s1    <= ctl_in;
		end
	end

	spdf_format u_fmt (
		.cfg    (cfg_q),
		.sample (sample_s1),
		.ctl    (ctl_s1),
		.res    (res_comb)
	);

	// result stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid   = valid_s2;
	assign high_byte   = res_s2.high_byte;
	assign low_byte    = res_s2.low_byte;
	assign two_bytes   = res_s2.two_bytes;
	assign pixel_end   = res_s2.pixel_end;
	assign depth_error = res_s2.depth_error;

	`SPDF_ASSERT_IMP(a_err_zero, out_valid && depth_error, low_byte == 8'd0 && !two_bytes)
	`SPDF_ASSERT_IMP(a_narrow_high, out_valid && !two_bytes, high_byte == 8'd0)
	`SPDF_ASSERT_NXT(a_s1_hold, valid_s1 && !ready_s2, valid_s1 && $stable(sample_s1))

endmodule
`default_nettype wire

>>> rtl/spdf_comp_ctr.sv
// Component counter: tracks the component within the pixel.
// Depends on spdf_pkg and the assertion macro header.
`default_nettype none
`include "sample_to_png_depth_formatter_macros.svh"
module spdf_comp_ctr (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire spdf_pkg::cfg_t cfg,
	input  wire logic          advance,
	output spdf_pkg::ctl_t     ctl
);

	logic [1:0] idx_q;
	logic [2:0] count;
	logic [1:0] last_idx;

	always_comb begin
		count    = spdf_pkg::norm_count(cfg.component_count);
		last_idx = 2'(count - 3'd1);
		ctl.idx  = ({1'b0, idx_q} >= count) ? last_idx : idx_q;
		ctl.last = (ctl.idx == last_idx);
		ctl.is_alpha = ((count == 3'd2) && (ctl.idx == 2'd1)) ||
			((count == 3'd4) && (ctl.idx == 2'd3));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (advance) begin
			idx_q <= ctl.last ? 2'd0 : 2'(ctl.idx + 2'd1);
		end
	end

	`SPDF_ASSERT_NXT(a_wrap_on_last, advance && ctl.last, idx_q == 2'd0)
	`SPDF_ASSERT_IMP(a_idx_in_count, 1'b1, {1'b0, ctl.idx} < count)
	`SPDF_ASSERT_NXT(a_hold_idle, !advance, $stable(idx_q))

endmodule
`default_nettype wire

>>> rtl/spdf_format.sv
// Sample datapath: level shift, clamp, depth expansion and byte split.
// Depends on spdf_pkg.
`default_nettype none
module spdf_format (
	input  wire spdf_pkg::cfg_t cfg,
	input  wire logic [31:0]    sample,
	input  wire spdf_pkg::ctl_t ctl,
	output spdf_pkg::res_t      res
);

	logic [4:0]  p;
	logic [4:0]  sp;
	logic [2:0]  count;
	logic        err;
	logic        wide;
	logic        force8;
	logic [30:0] off;
	logic [33:0] sum;
	logic [15:0] lim;
	logic [15:0] v;
	logic [7:0]  v8;
	logic [4:0]  u;
	logic [4:0]  rsh;
	logic [22:0] wsum;
	logic [2:0]  u8;
	logic [7:0]  nmask;
	logic [15:0] r;

	always_comb begin
		p      = cfg.sample_precision;
		count  = spdf_pkg::norm_count(cfg.component_count);
		err    = 1'b0;
		wide   = 1'b0;
		force8 = 1'b0;
		if (p == 5'd0 || p > 5'd16)
			err = 1'b1;
		else if (p > 5'd8)
			wide = 1'b1;
		else if (p < 5'd8) begin
			if (count > 3'd1)
				force8 = 1'b1;
			else if (p != 5'd1 && p != 5'd2 && p != 5'd4)
				err = 1'b1;
		end
		if (count == 3'd2 && cfg.alpha_precision != p)
			err = 1'b1;

		sp  = ctl.is_alpha ? cfg.alpha_precision : p;
		off = '0;
		if (cfg.signed_mask[ctl.idx] && sp != 5'd0)
			off = 31'd1 << (sp - 5'd1);
		sum = {{2{sample[31]}}, sample} + {3'b000, off};

		lim = wide ? spdf_pkg::LIM16 : spdf_pkg::LIM8;
		if (sum[33])
			v = 16'd0;
		else if (sum[32:0] > {17'd0, lim})
			v = lim;
		else
			v = sum[15:0];
		v8 = v[7:0];

		u     = 5'd16 - p;
		rsh   = p - u;
		wsum  = ({7'd0, v} << u[2:0]) + ({7'd0, v} >> rsh[3:0]);
		u8    = 3'(4'd8 - p[3:0]);
		nmask = 8'((9'd1 << p[3:0]) - 9'd1);

		if (wide)
			r = (p == 5'd16) ? v : wsum[15:0];
		else if (force8)
			r = {8'd0, 8'((v8 << u8) + (v8 >> p[2:0]))};
		else if (p == 5'd8)
			r = {8'd0, v8};
		else
			r = {8'd0, v8 & nmask};

		res.high_byte   = (err || !wide) ? 8'd0 : r[15:8];
		res.low_byte    = err ? 8'd0 : r[7:0];
		res.two_bytes   = !err && wide;
		res.pixel_end   = ctl.last;
		res.depth_error = err;
	end

endmodule
`default_nettype wire
